// ===== rtl/core/icu_pkg.sv =====
// Shared types and constants for the id cache with use-bit replacement.
package icu_pkg;

    // Input item and result item as they cross the ports
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] entry_id;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] evicted_id;
        logic [7:0]  evicted_count;
    } out_item_t;

    // Mode codes
    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_PIN    = 3'd2;
    localparam logic [2:0] MODE_UNPIN  = 3'd3;
    localparam logic [2:0] MODE_MOVE   = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    // Status codes
    localparam logic [3:0] ST_FOUND_PINNED   = 4'd0;
    localparam logic [3:0] ST_FOUND_CACHED   = 4'd1;
    localparam logic [3:0] ST_NOT_FOUND      = 4'd2;
    localparam logic [3:0] ST_MERGED_PINNED  = 4'd3;
    localparam logic [3:0] ST_MERGED_CACHED  = 4'd4;
    localparam logic [3:0] ST_INSERTED       = 4'd5;
    localparam logic [3:0] ST_INSERTED_EVICT = 4'd6;
    localparam logic [3:0] ST_REFUSED        = 4'd7;
    localparam logic [3:0] ST_UNPINNED       = 4'd8;
    localparam logic [3:0] ST_NOT_PRESENT    = 4'd9;
    localparam logic [3:0] ST_PIN_ADDED      = 4'd10;
    localparam logic [3:0] ST_CLEARED        = 4'd11;

    // Reset value of the cache limit register
    localparam logic [7:0] LIMIT_RESET = 8'd100;

    // Operation class decided by the front end
    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_PIN,
        OP_UNPIN,
        OP_MOVE,
        OP_CLEAR,
        OP_NONE
    } op_t;

    // Command held in the queue between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] id;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PSCAN,
        S_PDEC,
        S_CSCAN,
        S_CDEC,
        S_ESCAN,
        S_EDEC,
        S_FREE,
        S_DONE
    } bk_state_t;

endpackage

// ===== rtl/core/icu_front.sv =====
// Front end: accepts items, decodes the mode and queues commands.
module icu_front
    import icu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     q_valid,
    output cmd_t     q_cmd,
    input  logic     q_pop
);

    cmd_t       slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    cmd_t       dec;

    // Mode decode
    always_comb
    begin
        dec.id = in_data.entry_id;
        case (in_data.mode)
            MODE_LOOKUP: dec.op = OP_LOOKUP;
            MODE_ADD:    dec.op = OP_ADD;
            MODE_PIN:    dec.op = OP_PIN;
            MODE_UNPIN:  dec.op = OP_UNPIN;
            MODE_MOVE:   dec.op = OP_MOVE;
            MODE_CLEAR:  dec.op = OP_CLEAR;
            default:     dec.op = OP_NONE;
        endcase
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = slot_reg[rp_reg];

    // Queue pointers and fill level
    always_comb
    begin
        wp_next   = wp_reg ^ push;
        rp_next   = rp_reg ^ q_pop;
        fill_next = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= dec;
    end

endmodule

// ===== rtl/core/icu_back.sv =====
// Back end: walks the pinned and cache tables and applies each command.
module icu_back
    import icu_pkg::*;
#(
    parameter int CACHE_DEPTH  = 128,
    parameter int PINNED_DEPTH = 64,
    localparam int CIW = $clog2(CACHE_DEPTH),
    localparam int PIW = (PINNED_DEPTH > 1) ? $clog2(PINNED_DEPTH) : 1,
    localparam int CCW = $clog2(CACHE_DEPTH + 1),
    localparam int MXD = (CACHE_DEPTH > PINNED_DEPTH) ? CACHE_DEPTH : PINNED_DEPTH,
    localparam int SW  = $clog2(MXD + 1),
    localparam int KW  = (CCW > 8) ? CCW : 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     limit,
    input  logic           q_valid,
    input  cmd_t           q_cmd,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output out_item_t      res_item,
    output logic [CCW-1:0] cnt,
    output logic [CCW-1:0] used
);

    localparam logic [SW-1:0]  CD_S = SW'(CACHE_DEPTH);
    localparam logic [SW-1:0]  PD_S = SW'(PINNED_DEPTH);
    localparam logic [CCW-1:0] CD_C = CCW'(CACHE_DEPTH);

    bk_state_t st_reg, st_next;
    op_t       op_reg, op_next;
    logic [31:0] id_reg, id_next;
    logic [SW-1:0] addr_reg, addr_next;
    logic      pend_reg, pend_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic      phit_reg, phit_next;
    logic [SW-1:0] phidx_reg, phidx_next;
    logic      pfree_reg, pfree_next;
    logic [SW-1:0] pfidx_reg, pfidx_next;
    logic      chit_reg, chit_next;
    logic [SW-1:0] chidx_reg, chidx_next;
    logic      best_reg, best_next;
    logic [SW-1:0] bidx_reg, bidx_next;
    logic [31:0] bid_reg, bid_next;
    logic      evany_reg, evany_next;
    logic [31:0] evfirst_reg, evfirst_next;
    logic [7:0] evcnt_reg, evcnt_next;
    logic [3:0] stat_reg, stat_next;
    logic [CCW-1:0] cnt_reg, cnt_next;
    logic [CCW-1:0] used_reg, used_next;
    logic [CACHE_DEPTH-1:0]  cval_reg, cval_next;
    logic [CACHE_DEPTH-1:0]  cuse_reg, cuse_next;
    logic [PINNED_DEPTH-1:0] pval_reg, pval_next;
    logic      rv_reg, rv_next;
    out_item_t res_reg, res_next;

    // Table memories
    logic [31:0] cache_mem [CACHE_DEPTH];
    logic [31:0] pin_mem [PINNED_DEPTH];
    logic [31:0] crd_reg, prd_reg;
    logic        cwe, pwe;
    logic [CIW-1:0] cwa;
    logic [PIW-1:0] pwa;

    logic [CIW-1:0] ci, cs, cb;
    logic [PIW-1:0] pi;
    logic [CCW-1:0] used_t, cnt_dec;
    logic [KW-1:0]  lim_k;

    assign lim_k = KW'(limit);
    assign ci    = pidx_reg[CIW-1:0];
    assign pi    = pidx_reg[PIW-1:0];
    assign cs    = chidx_reg[CIW-1:0];
    assign cb    = bidx_reg[CIW-1:0];
    assign cnt_dec = cnt_reg - 1'b1;
    assign used_t  = used_reg + {{(CCW-1){1'b0}}, !cuse_reg[cs]};

    always_ff @(posedge clk)
    begin
        if (cwe)
            cache_mem[cwa] <= id_reg;
        crd_reg <= cache_mem[addr_reg[CIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
            pin_mem[pwa] <= id_reg;
        prd_reg <= pin_mem[addr_reg[PIW-1:0]];
    end

    assign res_valid = rv_reg;
    assign res_item  = res_reg;
    assign cnt       = cnt_reg;
    assign used      = used_reg;

    // Sequencer
    always_comb
    begin
        st_next = st_reg;  op_next = op_reg;  id_next = id_reg;
        addr_next = addr_reg;  pend_next = 1'b0;  pidx_next = pidx_reg;
        phit_next = phit_reg;  phidx_next = phidx_reg;
        pfree_next = pfree_reg;  pfidx_next = pfidx_reg;
        chit_next = chit_reg;  chidx_next = chidx_reg;
        best_next = best_reg;  bidx_next = bidx_reg;  bid_next = bid_reg;
        evany_next = evany_reg;  evfirst_next = evfirst_reg;  evcnt_next = evcnt_reg;
        stat_next = stat_reg;  cnt_next = cnt_reg;  used_next = used_reg;
        cval_next = cval_reg;  cuse_next = cuse_reg;  pval_next = pval_reg;
        rv_next = rv_reg && !res_ready;  res_next = res_reg;
        q_pop = 1'b0;  cwe = 1'b0;  pwe = 1'b0;
        cwa = cs;  pwa = pfidx_reg[PIW-1:0];

        case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    op_next = q_cmd.op;  id_next = q_cmd.id;
                    addr_next = '0;  phit_next = 1'b0;  pfree_next = 1'b0;
                    chit_next = 1'b0;
                    evany_next = 1'b0;  evfirst_next = '0;  evcnt_next = '0;
                    case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            pval_next = '0;
                            stat_next = ST_CLEARED;
                            st_next = S_DONE;
                        end
                        OP_NONE:
                        begin
                            stat_next = ST_NOT_FOUND;
                            st_next = S_DONE;
                        end
                        default: st_next = S_PSCAN;
                    endcase
                end
            end

            // Pinned table walk: match and lowest free slot
            S_PSCAN:
            begin
                if (addr_reg < PD_S)
                begin
                    pend_next = 1'b1;  pidx_next = addr_reg;  addr_next = addr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (pval_reg[pi] && prd_reg == id_reg && !phit_reg)
                    begin
                        phit_next = 1'b1;  phidx_next = pidx_reg;
                    end
                    if (!pval_reg[pi] && !pfree_reg)
                    begin
                        pfree_next = 1'b1;  pfidx_next = pidx_reg;
                    end
                end
                if (addr_reg == PD_S && !pend_reg)
                    st_next = S_PDEC;
            end

            S_PDEC:
            begin
                addr_next = '0;
                st_next = S_DONE;
                case (op_reg)
                    OP_LOOKUP:
                        if (phit_reg) stat_next = ST_FOUND_PINNED;
                        else st_next = S_CSCAN;
                    OP_ADD:
                        if (phit_reg) stat_next = ST_MERGED_PINNED;
                        else st_next = S_CSCAN;
                    OP_PIN:
                        if (phit_reg) stat_next = ST_MERGED_PINNED;
                        else if (pfree_reg)
                        begin
                            pwe = 1'b1;
                            pval_next[pfidx_reg[PIW-1:0]] = 1'b1;
                            stat_next = ST_PIN_ADDED;
                        end
                        else stat_next = ST_REFUSED;
                    OP_UNPIN:
                        if (phit_reg)
                        begin
                            pval_next[phidx_reg[PIW-1:0]] = 1'b0;
                            stat_next = ST_UNPINNED;
                        end
                        else stat_next = ST_NOT_PRESENT;
                    OP_MOVE:
                        if (phit_reg) st_next = S_CSCAN;
                        else stat_next = ST_NOT_PRESENT;
                    default: stat_next = ST_NOT_FOUND;
                endcase
            end

            // Cache table walk: match
            S_CSCAN:
            begin
                if (addr_reg < CD_S)
                begin
                    pend_next = 1'b1;  pidx_next = addr_reg;  addr_next = addr_reg + 1'b1;
                end
                if (pend_reg && cval_reg[ci] && crd_reg == id_reg && !chit_reg)
                begin
                    chit_next = 1'b1;  chidx_next = pidx_reg;
                end
                if (addr_reg == CD_S && !pend_reg)
                    st_next = S_CDEC;
            end

            S_CDEC:
            begin
                addr_next = '0;
                best_next = 1'b0;
                if (chit_reg)
                begin
                    // Hit: set use bit, clear the rest once all are set at the limit
                    cuse_next[cs] = 1'b1;
                    used_next = used_t;
                    if (KW'(cnt_reg) >= lim_k && used_t == cnt_reg)
                    begin
                        cuse_next = '0;
                        cuse_next[cs] = 1'b1;
                        used_next = {{(CCW-1){1'b0}}, 1'b1};
                    end
                    if (op_reg == OP_MOVE)
                        pval_next[phidx_reg[PIW-1:0]] = 1'b0;
                    stat_next = (op_reg == OP_LOOKUP) ? ST_FOUND_CACHED : ST_MERGED_CACHED;
                    st_next = S_DONE;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    stat_next = ST_NOT_FOUND;
                    st_next = S_DONE;
                end
                else if (KW'(cnt_reg) >= lim_k)
                    st_next = S_ESCAN;
                else if (cnt_reg < CD_C)
                    st_next = S_FREE;
                else
                begin
                    stat_next = ST_REFUSED;
                    st_next = S_DONE;
                end
            end

            // Eviction walk: lowest id with a clear use bit
            S_ESCAN:
            begin
                if (addr_reg < CD_S)
                begin
                    pend_next = 1'b1;  pidx_next = addr_reg;  addr_next = addr_reg + 1'b1;
                end
                if (pend_reg && cval_reg[ci] && !cuse_reg[ci] && (!best_reg || crd_reg < bid_reg))
                begin
                    best_next = 1'b1;  bidx_next = pidx_reg;  bid_next = crd_reg;
                end
                if (addr_reg == CD_S && !pend_reg)
                    st_next = S_EDEC;
            end

            S_EDEC:
            begin
                addr_next = '0;
                best_next = 1'b0;
                if (best_reg)
                begin
                    cval_next[cb] = 1'b0;
                    cuse_next[cb] = 1'b0;
                    cnt_next = cnt_dec;
                    evcnt_next = evcnt_reg + 1'b1;
                    evany_next = 1'b1;
                    if (!evany_reg)
                        evfirst_next = bid_reg;
                    st_next = (KW'(cnt_dec) >= lim_k) ? S_ESCAN : S_FREE;
                end
                else if (cnt_reg < CD_C)
                    st_next = S_FREE;
                else
                begin
                    stat_next = ST_REFUSED;
                    st_next = S_DONE;
                end
            end

            // Lowest free cache slot, one valid bit a cycle
            S_FREE:
            begin
                addr_next = addr_reg + 1'b1;
                if (!cval_reg[addr_reg[CIW-1:0]])
                begin
                    cwe = 1'b1;
                    cwa = addr_reg[CIW-1:0];
                    cval_next[addr_reg[CIW-1:0]] = 1'b1;
                    cuse_next[addr_reg[CIW-1:0]] = 1'b0;
                    cnt_next = cnt_reg + 1'b1;
                    if (op_reg == OP_MOVE)
                        pval_next[phidx_reg[PIW-1:0]] = 1'b0;
                    stat_next = evany_reg ? ST_INSERTED_EVICT : ST_INSERTED;
                    st_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rv_reg || res_ready)
                begin
                    rv_next = 1'b1;
                    res_next.status = stat_reg;
                    res_next.evicted_id = evfirst_reg;
                    res_next.evicted_count = evcnt_reg;
                    st_next = S_IDLE;
                end
            end

            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;  pend_reg <= 1'b0;  rv_reg <= 1'b0;
            cnt_reg <= '0;  used_reg <= '0;
            cval_reg <= '0;  cuse_reg <= '0;  pval_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;  pend_reg <= pend_next;  rv_reg <= rv_next;
            cnt_reg <= cnt_next;  used_reg <= used_next;
            cval_reg <= cval_next;  cuse_reg <= cuse_next;  pval_reg <= pval_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;  id_reg <= id_next;  addr_reg <= addr_next;
        pidx_reg <= pidx_next;  phit_reg <= phit_next;  phidx_reg <= phidx_next;
        pfree_reg <= pfree_next;  pfidx_reg <= pfidx_next;
        chit_reg <= chit_next;  chidx_reg <= chidx_next;
        best_reg <= best_next;  bidx_reg <= bidx_next;  bid_reg <= bid_next;
        evany_reg <= evany_next;  evfirst_reg <= evfirst_next;  evcnt_reg <= evcnt_next;
        stat_reg <= stat_next;  res_reg <= res_next;
    end

endmodule

// ===== rtl/core/id_cache_with_use_bit_replacement_core.sv =====
// Walks: lookup, add and move walk the pinned table and, where needed, the cache table; pin and
//   unpin walk only the pinned table, clear and unused modes none. Each eviction adds a walk of
//   the cache table and an insert walks up to CACHE_DEPTH valid bits. One table read a cycle.
// Throughput: one item at a time in the back end; a two-entry queue and the result register
//   let new items be taken while one is worked on or a result waits.
// Reset: asynchronous, active low; clears all valid and use bits and sets the limit to 100.
module id_cache_with_use_bit_replacement_core
    import icu_pkg::*;
#(
    parameter int CACHE_DEPTH  = 128,
    parameter int PINNED_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int CCW = $clog2(CACHE_DEPTH + 1);

    logic [7:0] limit_reg;
    logic       q_valid, q_pop;
    cmd_t       q_cmd;
    logic [CCW-1:0] cnt, used;

    // Limit register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    icu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    icu_back #(
        .CACHE_DEPTH  (CACHE_DEPTH),
        .PINNED_DEPTH (PINNED_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res_item  (out_data),
        .cnt       (cnt),
        .used      (used)
    );

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("back end took an item from an empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CCW'(CACHE_DEPTH))
        else $error("cache entry count above depth");
    a_used_le_cnt: assert property (@(posedge clk) disable iff (!rst_n) used <= cnt)
        else $error("more use bits set than valid entries");
`endif

endmodule
